### rtl/core/rsi_pkg.sv
// rsi_pkg: shared types, character codes and digit decode for the radix
// string-to-integer parser. No dependencies.
package rsi_pkg;

  // parse phases, one-hot
  typedef enum logic [4:0] {
    PhSpace  = 5'b00001,
    PhPrefix = 5'b00010,
    PhZero   = 5'b00100,
    PhDigits = 5'b01000,
    PhDone   = 5'b10000
  } phase_e;

  localparam int RadixW   = 6;
  localparam int ValueW   = 64;
  localparam int OffsetW  = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRadix  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSigned = 2'd1;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  localparam logic [7:0] DigitNone = 8'hff;

  localparam logic [RadixW-1:0] RadixAuto = 6'd0;
  localparam logic [RadixW-1:0] RadixOct  = 6'd8;
  localparam logic [RadixW-1:0] RadixDec  = 6'd10;
  localparam logic [RadixW-1:0] RadixHex  = 6'd16;

  typedef struct packed {
    phase_e              phase;
    logic [ValueW-1:0]   acc;
    logic                minus;
    logic [RadixW-1:0]   act_radix;
    logic                digit_seen;
  } parse_state_t;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic              signed_mode;
  } cfg_t;

  localparam parse_state_t StateReset = '{
    phase:      PhSpace,
    acc:        '0,
    minus:      1'b0,
    act_radix:  '0,
    digit_seen: 1'b0
  };

  // digit value of a character, DigitNone when it is no digit at all
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = DigitNone;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h7a]}) begin
      d = c - 8'h57;
    end else if (c inside {[8'h41:8'h5a]}) begin
      d = c - 8'h37;
    end
    return d;
  endfunction

endpackage

### rtl/core/rsi_in_reg.sv
// rsi_in_reg: input register of the parser, holds one character request
// until the parse step takes it. No dependencies.
module rsi_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;

  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

### rtl/core/rsi_step.sv
// rsi_step: combinational parse of one character against the current parse
// state, including the end-of-string result. Uses rsi_pkg.
module rsi_step #(
  parameter int MaxLen = 4096,
  parameter int PosW   = 13
) (
  input  rsi_pkg::parse_state_t       state_i,
  input  logic [PosW-1:0]             pos_i,
  input  logic [PosW-1:0]             stop_i,
  input  logic [7:0]                  char_i,
  input  logic                        last_i,
  input  rsi_pkg::cfg_t               cfg_i,
  output rsi_pkg::parse_state_t       state_o,
  output logic [PosW-1:0]             pos_o,
  output logic [PosW-1:0]             stop_o,
  output logic [rsi_pkg::ValueW-1:0]  value_o,
  output logic [rsi_pkg::OffsetW-1:0] end_offset_o,
  output logic                        converted_o
);

  localparam int ExtW = (PosW > rsi_pkg::OffsetW) ? PosW : rsi_pkg::OffsetW;

  rsi_pkg::parse_state_t st;
  logic [PosW-1:0]       pos;
  logic [PosW-1:0]       stop;
  logic [PosW-1:0]       pos_adv;
  logic [7:0]            dig;
  logic                  do_prefix;
  logic                  take;
  logic [ExtW-1:0]       stop_ext;
  logic [rsi_pkg::ValueW-1:0] mag;

  // saturating position after consuming this character
  assign pos_adv = (pos_i < PosW'(MaxLen)) ? pos_i + PosW'(1) : pos_i;
  assign dig     = rsi_pkg::digit_of(char_i);

  always_comb begin
    st        = state_i;
    pos       = pos_i;
    stop      = stop_i;
    do_prefix = 1'b0;
    take      = 1'b0;

    case (state_i.phase)
      rsi_pkg::PhSpace: begin
        if (char_i == rsi_pkg::ChSpace || char_i == rsi_pkg::ChTab) begin
          pos = pos_adv;
        end else if (char_i == rsi_pkg::ChPlus || char_i == rsi_pkg::ChMinus) begin
          st.minus = (char_i == rsi_pkg::ChMinus);
          st.phase = rsi_pkg::PhPrefix;
          pos      = pos_adv;
        end else begin
          do_prefix = 1'b1;
        end
      end
      rsi_pkg::PhPrefix: begin
        do_prefix = 1'b1;
      end
      rsi_pkg::PhZero: begin
        if (char_i == rsi_pkg::ChLowX || char_i == rsi_pkg::ChUpX) begin
          st.act_radix = rsi_pkg::RadixHex;
          st.phase     = rsi_pkg::PhDigits;
          pos          = pos_adv;
        end else begin
          if (st.act_radix == rsi_pkg::RadixAuto) begin
            st.act_radix = rsi_pkg::RadixOct;
          end else begin
            // hex radix: the lone zero is itself a digit
            st.acc        = '0;
            st.digit_seen = 1'b1;
            stop          = pos_i;
          end
          st.phase = rsi_pkg::PhDigits;
          take     = 1'b1;
        end
      end
      rsi_pkg::PhDigits: begin
        take = 1'b1;
      end
      rsi_pkg::PhDone: begin
        st = state_i;
      end
      default: begin
        st = state_i;
      end
    endcase

    if (do_prefix) begin
      if (char_i == rsi_pkg::ChZero &&
          (cfg_i.radix == rsi_pkg::RadixAuto || cfg_i.radix == rsi_pkg::RadixHex)) begin
        st.act_radix = cfg_i.radix;
        st.phase     = rsi_pkg::PhZero;
        pos          = pos_adv;
      end else begin
        st.act_radix = (cfg_i.radix == rsi_pkg::RadixAuto) ? rsi_pkg::RadixDec : cfg_i.radix;
        st.phase     = rsi_pkg::PhDigits;
        take         = 1'b1;
      end
    end

    if (take) begin
      if (dig >= {2'b00, st.act_radix}) begin
        st.phase = rsi_pkg::PhDone;
      end else begin
        st.acc        = st.acc * {58'd0, st.act_radix} + {56'd0, dig};
        st.digit_seen = 1'b1;
        pos           = pos_adv;
        stop          = pos_adv;
      end
    end

    // string ends in the zero phase: an implied terminator follows
    if (last_i && st.phase == rsi_pkg::PhZero) begin
      st.phase = rsi_pkg::PhDone;
      if (st.act_radix != rsi_pkg::RadixAuto) begin
        st.acc        = '0;
        st.digit_seen = 1'b1;
        stop          = pos;
      end
    end
  end

  assign mag      = st.digit_seen ? st.acc : '0;
  assign stop_ext = ExtW'(stop);

  assign value_o      = (cfg_i.signed_mode && st.minus) ? ('0 - mag) : mag;
  assign end_offset_o = st.digit_seen ? stop_ext[rsi_pkg::OffsetW-1:0] : '0;
  assign converted_o  = st.digit_seen;

  assign state_o = last_i ? rsi_pkg::StateReset : st;
  assign pos_o   = last_i ? '0 : pos;
  assign stop_o  = last_i ? '0 : stop;

endmodule

### rtl/core/radix_string_to_integer.sv
// radix_string_to_integer: top level of the streaming string-to-integer
// parser. Instantiates rsi_in_reg and rsi_step, uses rsi_pkg.
//
// The block takes one character request per clock cycle and parses the
// string into a 64-bit value, with leading blanks, an optional sign, a radix
// prefix for automatic or hex radix, and letters as digits 10 to 35. Each
// character passes an input register and then one parse step that updates
// the parse state register (one 64 by 6 bit multiply-add); the result for
// a string is loaded into the output register as its last character
// leaves the input register. Characters that end no string keep flowing
// while a result waits to be taken; a last character waits in the input
// register until the output register is free. Configuration writes are always
// accepted and must be made while no string is in flight.
module radix_string_to_integer #(
  parameter int MaxLen = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  char_byte_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rsi_pkg::ValueW-1:0]  value_o,
  output logic [rsi_pkg::OffsetW-1:0] end_offset_o,
  output logic                        converted_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rsi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rsi_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int PosW = $clog2(MaxLen + 1);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       take;

  rsi_pkg::cfg_t         cfg_q, cfg_d;
  rsi_pkg::parse_state_t state_q, state_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [PosW-1:0]       stop_q, stop_d;

  logic                        out_valid_q, out_valid_d;
  logic [rsi_pkg::ValueW-1:0]  value_q, value_d;
  logic [rsi_pkg::OffsetW-1:0] end_offset_q, end_offset_d;
  logic                        converted_q, converted_d;

  // a last character needs a free output register
  assign take = s1_valid & (~s1_last | ~out_valid_q | ~out_stall_i);

  rsi_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_byte_i (char_byte_i),
    .last_i      (last_i),
    .take_i      (take),
    .valid_o     (s1_valid),
    .char_o      (s1_char),
    .last_o      (s1_last)
  );

  rsi_step #(
    .MaxLen (MaxLen),
    .PosW   (PosW)
  ) u_step (
    .state_i      (state_q),
    .pos_i        (pos_q),
    .stop_i       (stop_q),
    .char_i       (s1_char),
    .last_i       (s1_last),
    .cfg_i        (cfg_q),
    .state_o      (state_d),
    .pos_o        (pos_d),
    .stop_o       (stop_d),
    .value_o      (value_d),
    .end_offset_o (end_offset_d),
    .converted_o  (converted_d)
  );

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rsi_pkg::CfgRadix:  cfg_d.radix       = cfg_wdata_i;
        rsi_pkg::CfgSigned: cfg_d.signed_mode = cfg_wdata_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && s1_last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{radix: rsi_pkg::RadixAuto, signed_mode: 1'b1};
      state_q     <= rsi_pkg::StateReset;
      pos_q       <= '0;
      stop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      if (take) begin
        state_q <= state_d;
        pos_q   <= pos_d;
        stop_q  <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && s1_last) begin
      value_q      <= value_d;
      end_offset_q <= end_offset_d;
      converted_q  <= converted_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = end_offset_q;
  assign converted_o  = converted_q;

endmodule

### rtl/core/rsi_checker.sv
// rsi_checker: port-level assertions for radix_string_to_integer, bound to
// the top level below. Uses only the top level's ports.
module rsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] value_o,
  input logic [12:0] end_offset_o,
  input logic        converted_o
);

  // a stalled result stays and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) &&
    $stable(end_offset_o) && $stable(converted_o))
    else $error("stalled result changed");

  // input backs up only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // no digit means a zero value and zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converted_o |-> value_o == 64'd0 && end_offset_o == 13'd0)
    else $error("unconverted result not zero");

endmodule

bind radix_string_to_integer rsi_checker u_rsi_checker (.*);

### dv/tb_radix_string_to_integer.sv
// tb_radix_string_to_integer: self-checking bench for the streaming radix
// string-to-integer parser, with an in-bench parse predictor and random idling.
// Depends on rsi_pkg and radix_string_to_integer.
module tb_radix_string_to_integer;
  timeunit 1ns;
  timeprecision 1ps;

  import rsi_pkg::*;

  localparam int MaxLen      = 4096;
  localparam int RandomBytes = 1000;
  localparam int PhaseBytes  = 120;
  localparam int LongHold    = 300;
  // longest quiet stretch of a good run is the long hold plus a few gaps
  localparam int IdleLimit   = 3000;

  // indexes the block has no register behind
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChTilde = 8'h7e;  // stands for NUL in table text

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] end_offset;
    logic               converted;
  } number_t;

  typedef struct {
    logic [RadixW-1:0] radix;
    logic              sgn;
    string             text;
    bit                typed;
    number_t           number;
  } string_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          char_byte_i = '0;
  logic                last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ValueW-1:0]   value_o;
  logic [OffsetW-1:0]  end_offset_o;
  logic                converted_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  radix_string_to_integer #(
    .MaxLen(MaxLen)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .char_byte_i,
    .last_i,
    .out_valid_o,
    .out_stall_i,
    .value_o,
    .end_offset_o,
    .converted_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the registers and the parse state
  logic [RadixW-1:0] cfg_radix  = RadixAuto;
  logic              cfg_signed = 1'b1;
  phase_e            ph         = PhSpace;
  logic [ValueW-1:0] acc        = '0;
  logic              minus      = 1'b0;
  logic [RadixW-1:0] act_radix  = '0;
  int unsigned       pos        = 0;
  int unsigned       stop_pos   = 0;
  logic              dseen      = 1'b0;

  number_t     parsed_numbers[$];
  string_row_t string_rows[$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;
  bit          long_hold_req = 1'b0;

  function automatic int unsigned digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 255;
  endfunction

  function automatic void clear_parse();
    ph        = PhSpace;
    acc       = '0;
    minus     = 1'b0;
    act_radix = '0;
    pos       = 0;
    stop_pos  = 0;
    dseen     = 1'b0;
  endfunction

  function automatic void bump_pos();
    if (pos < MaxLen) pos++;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    int unsigned d;
    d = digit_value(c);
    if (d >= act_radix) begin
      ph = PhDone;
      return;
    end
    acc   = acc * ValueW'(act_radix) + ValueW'(d);
    dseen = 1'b1;
    bump_pos();
    stop_pos = pos;
  endfunction

  function automatic void consume(logic [7:0] c);
    if (ph == PhSpace) begin
      if (c == ChSpace || c == ChTab) begin
        bump_pos();
        return;
      end
      ph = PhPrefix;
      if (c == ChPlus || c == ChMinus) begin
        minus = (c == ChMinus);
        bump_pos();
        return;
      end
    end
    if (ph == PhPrefix) begin
      if (c == ChZero && (cfg_radix == RadixAuto || cfg_radix == RadixHex)) begin
        act_radix = cfg_radix;
        bump_pos();
        ph = PhZero;
        return;
      end
      act_radix = (cfg_radix == RadixAuto) ? RadixDec : cfg_radix;
      ph = PhDigits;
      take_digit(c);
      return;
    end
    if (ph == PhZero) begin
      if (c == ChLowX || c == ChUpX) begin
        act_radix = RadixHex;
        bump_pos();
        ph = PhDigits;
        return;
      end
      if (act_radix == RadixAuto) begin
        act_radix = RadixOct;
      end else begin
        // fixed hex radix: the leading zero already counts as a digit
        acc      = '0;
        dseen    = 1'b1;
        stop_pos = pos;
      end
      ph = PhDigits;
      take_digit(c);
      return;
    end
    if (ph == PhDigits) take_digit(c);
  endfunction

  function automatic bit parse_byte(logic [7:0] c, logic fin, output number_t num);
    consume(c);
    num = '0;
    if (!fin) return 1'b0;
    // string ended inside the prefix, as if a NUL followed
    if (ph == PhZero) consume(ChNul);
    num.value = dseen ? acc : '0;
    if (cfg_signed && minus) num.value = -num.value;
    num.end_offset = dseen ? OffsetW'(stop_pos) : '0;
    num.converted  = dseen;
    clear_parse();
    return 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] c, logic fin, bit typed, number_t typed_num);
    int      gap;
    number_t num;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    last_i      <= fin;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_byte(c, fin, num)) parsed_numbers.push_back(typed ? typed_num : num);
  endtask

  task automatic send_text(logic [7:0] text[$], bit typed, number_t typed_num);
    tx_burst = ($urandom_range(0, 3) == 0);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1, typed, typed_num);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (parsed_numbers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgRadix) cfg_radix = data;
    else if (idx == CfgSigned) cfg_signed = data[0];
  endtask

  task automatic set_config(logic [RadixW-1:0] r, logic s);
    write_reg(CfgRadix, r);
    // upper data bits are don't-care for the sign register
    write_reg(CfgSigned, CfgDataW'({5'($urandom_range(0, 31)), s}));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(logic [RadixW-1:0] r, logic s, string t, bit typed = 1'b0,
                         logic [ValueW-1:0] v = '0, int off = 0, logic conv = 1'b0);
    string_row_t row;
    row.radix  = r;
    row.sgn    = s;
    row.text   = t;
    row.typed  = typed;
    row.number.value      = v;
    row.number.end_offset = OffsetW'(off);
    row.number.converted  = conv;
    string_rows.push_back(row);
  endtask

  // result checker
  always @(posedge clk_i) begin
    number_t got;
    number_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.value      = value_o;
      got.end_offset = end_offset_o;
      got.converted  = converted_o;
      if (parsed_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected request out: value %h offset %0d converted %0b",
                   got.value, got.end_offset, got.converted);
      end else begin
        want = parsed_numbers.pop_front();
        if (got.value != want.value || got.end_offset != want.end_offset ||
            got.converted != want.converted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %h/%h offset %0d/%0d converted %0b/%0b (exp/act)",
                     want.value, got.value, want.end_offset, got.end_offset,
                     want.converted, got.converted);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 8 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (long_hold_req) begin
        gap = LongHold;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    logic [7:0]        text[$];
    logic [RadixW-1:0] r;
    number_t           big;
    int unsigned       sent, budget, span, n, d;

    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings; typed results only where they are obvious
    add_row(RadixAuto, 1'b1, " \t-42", 1'b1, -64'd42, 5, 1'b1);
    add_row(RadixAuto, 1'b1, "0x1F");
    add_row(RadixAuto, 1'b1, "0X", 1'b1);
    add_row(RadixAuto, 1'b1, "0", 1'b1);
    add_row(RadixAuto, 1'b1, "0777");
    add_row(RadixAuto, 1'b1, "089", 1'b1);
    add_row(RadixAuto, 1'b1, "+12~34");
    add_row(RadixAuto, 1'b1, "-", 1'b1);
    add_row(RadixAuto, 1'b1, "-0x", 1'b1);
    add_row(RadixAuto, 1'b1, "12ab");
    add_row(RadixAuto, 1'b1, "~5", 1'b1);
    add_row(RadixDec, 1'b1, "18446744073709551615", 1'b1, '1, 20, 1'b1);
    add_row(RadixDec, 1'b1, "18446744073709551616");
    add_row(RadixDec, 1'b0, "-5", 1'b1, 64'd5, 2, 1'b1);
    add_row(RadixHex, 1'b0, "0", 1'b1, '0, 1, 1'b1);
    add_row(RadixHex, 1'b0, "0xffffffffffffffff", 1'b1, '1, 18, 1'b1);
    add_row(RadixHex, 1'b1, "-0abc");
    add_row(6'd1, 1'b1, "0001");
    add_row(6'd36, 1'b1, "zZ");
    add_row(6'd63, 1'b1, "Zz!");
    add_row(6'd2, 1'b1, "\377\200 1", 1'b1);
    add_row(RadixOct, 1'b1, "  +0x7");

    foreach (string_rows[i]) begin
      if (string_rows[i].radix != cfg_radix || string_rows[i].sgn != cfg_signed) begin
        wait_idle();
        set_config(string_rows[i].radix, string_rows[i].sgn);
      end
      text.delete();
      for (int k = 0; k < string_rows[i].text.len(); k++)
        text.push_back(string_rows[i].text[k] == ChTilde ? ChNul : string_rows[i].text[k]);
      send_text(text, string_rows[i].typed, string_rows[i].number);
    end

    // blanks up to just below the length limit and two digits: the position count saturates
    wait_idle();
    set_config(RadixDec, 1'b1);
    text.delete();
    repeat (MaxLen - 1) text.push_back(ChSpace);
    repeat (2) text.push_back(8'(ChZero + 8'd9));
    big.value      = 64'd99;
    big.end_offset = OffsetW'(MaxLen);
    big.converted  = 1'b1;
    send_text(text, 1'b1, big);

    sent = 0;
    while (sent < RandomBytes) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       r = RadixAuto;
        1:       r = RadixDec;
        2:       r = RadixHex;
        3:       r = RadixOct;
        4:       r = 6'd2;
        5:       r = 6'd36;
        6:       r = 6'd1;
        default: r = 6'($urandom_range(0, 63));
      endcase
      set_config(r, 1'($urandom_range(0, 1)));
      // first phase: hold results back so the block fills and stalls
      if (sent == 0) long_hold_req = 1'b1;
      budget = sent + PhaseBytes;
      while (sent < budget) begin
        text.delete();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(0, 3)) text.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
          case ($urandom_range(0, 2))
            1:       text.push_back(ChPlus);
            2:       text.push_back(ChMinus);
            default: ;
          endcase
          span = (cfg_radix == RadixAuto) ? RadixDec : cfg_radix;
          if (cfg_radix == RadixAuto || cfg_radix == RadixHex) begin
            case ($urandom_range(0, 3))
              0: begin
                text.push_back(ChZero);
                text.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
                span = RadixHex;
              end
              1: if (cfg_radix == RadixAuto) begin
                text.push_back(ChZero);
                span = RadixOct;
              end
              default: ;
            endcase
          end
          if (span > 36) span = 36;
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
          repeat (n) begin
            d = $urandom_range(0, span - 1);
            if (d < 10) text.push_back(8'(ChZero + d));
            else text.push_back(8'(($urandom_range(0, 1) ? ChLowA : ChUpA) + d - 10));
          end
          case ($urandom_range(0, 3))
            1: text.push_back(8'($urandom));
            2: begin
              text.push_back(ChNul);
              repeat ($urandom_range(0, 3)) text.push_back(8'($urandom));
            end
            default: ;
          endcase
          if (text.size() == 0) text.push_back(ChNul);
        end
        send_text(text, 1'b0, '0);
        sent += text.size();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && parsed_numbers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rsi_pkg.sv
rtl/core/rsi_in_reg.sv
rtl/core/rsi_step.sv
rtl/core/radix_string_to_integer.sv
rtl/core/rsi_checker.sv
dv/tb_radix_string_to_integer.sv
